### hw/rtl/cia_pkg.sv
// Package for the checked integer ALU: item types, operation codes,
// queue entry type and width helper functions. No dependencies.
package cia_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0]  mode;
      logic        is_signed;
      logic [1:0]  width_sel;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [63:0] result;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic        sgn;
      logic [1:0]  wsel;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] ua;
      logic [63:0] ub;
      logic        neg;
      logic        div_zero;
      logic        div_min_m1;
   } work_type;

   function automatic logic [63:0] mask_of(input logic [1:0] wsel);
      logic [63:0] m;
      case (wsel)
         2'd0:    m = 64'h0000_0000_0000_00ff;
         2'd1:    m = 64'h0000_0000_0000_ffff;
         2'd2:    m = 64'h0000_0000_ffff_ffff;
         default: m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
   endfunction

   function automatic logic [63:0] min_of(input logic [1:0] wsel);
      logic [63:0] m;
      case (wsel)
         2'd0:    m = 64'h0000_0000_0000_0080;
         2'd1:    m = 64'h0000_0000_0000_8000;
         2'd2:    m = 64'h0000_0000_8000_0000;
         default: m = 64'h8000_0000_0000_0000;
      endcase
      return m;
   endfunction

   function automatic logic top_of(input logic [63:0] x, input logic [1:0] wsel);
      logic t;
      case (wsel)
         2'd0:    t = x[7];
         2'd1:    t = x[15];
         2'd2:    t = x[31];
         default: t = x[63];
      endcase
      return t;
   endfunction

endpackage

### hw/rtl/cia_front.sv
// Front end: masks operands to the selected width and classifies the item
// (magnitudes, sign of result, divide special cases). Uses cia_pkg.
module cia_front import cia_pkg::*; (
   input  req_type  req_data,
   output work_type work
);

   logic [63:0] mask;
   logic [63:0] a;
   logic [63:0] b;
   logic        ta;
   logic        tb;

   always_comb begin
      mask = mask_of(req_data.width_sel);
      a    = req_data.operand_a & mask;
      b    = req_data.operand_b & mask;
      ta   = top_of(a, req_data.width_sel);
      tb   = top_of(b, req_data.width_sel);
      work.op         = op_type'(req_data.mode);
      work.sgn        = req_data.is_signed;
      work.wsel       = req_data.width_sel;
      work.a          = a;
      work.b          = b;
      work.ua         = (req_data.is_signed && ta) ? ((~a) + 64'd1) & mask : a;
      work.ub         = (req_data.is_signed && tb) ? ((~b) + 64'd1) & mask : b;
      work.neg        = req_data.is_signed && (ta ^ tb);
      work.div_zero   = (b == 64'd0);
      work.div_min_m1 = req_data.is_signed && (a == min_of(req_data.width_sel))
                        && (b == mask);
   end

endmodule

### hw/rtl/cia_queue.sv
// Short item queue between front and back ends. Uses cia_pkg.
module cia_queue import cia_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   input  logic     pop,
   output work_type pop_data,
   output logic     full,
   output logic     empty
);

   work_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0]   rptr_ff, rptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   assign full     = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/cia_back.sv
// Back end: executes one queued item at a time. Multiply accumulates four
// 32x32 partial products; divide is restoring, one bit per cycle. Uses cia_pkg.
module cia_back import cia_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     empty,
   input  work_type head,
   output logic     pop,
   output logic     rsp_strobe,
   output rsp_type  rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   work_type     cur_ff, cur_in;
   logic [127:0] acc_ff, acc_in;
   logic [64:0]  rem_ff, rem_in;
   logic [63:0]  quo_ff, quo_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         strobe_ff, strobe_in;
   rsp_type      rsp_ff, rsp_in;

   logic [63:0]  pp;
   logic [31:0]  pa;
   logic [31:0]  pb;
   logic [64:0]  trial;
   logic [63:0]  mask;
   logic [63:0]  r;
   logic [63:0]  lo;
   logic [63:0]  limit;
   logic         ovf;

   assign pop        = (state_ff == S_IDLE) && !empty;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      pa    = cnt_ff[1] ? cur_ff.ua[63:32] : cur_ff.ua[31:0];
      pb    = cnt_ff[0] ? cur_ff.ub[63:32] : cur_ff.ub[31:0];
      pp    = 64'(pa) * 64'(pb);
      trial = {rem_ff[63:0], quo_ff[63]};
      mask  = mask_of(cur_ff.wsel);
      lo    = acc_ff[63:0];
      r     = '0;
      ovf   = 1'b0;
      limit = '0;
      unique case (cur_ff.op)
         OP_ADD: begin
            r = (cur_ff.a + cur_ff.b) & mask;
            ovf = cur_ff.sgn ? top_of((cur_ff.a ^ r) & (cur_ff.b ^ r), cur_ff.wsel)
                             : (r < cur_ff.a);
         end
         OP_SUB: begin
            r = (cur_ff.a - cur_ff.b) & mask;
            ovf = cur_ff.sgn ? top_of((cur_ff.a ^ cur_ff.b) & (cur_ff.a ^ r), cur_ff.wsel)
                             : (cur_ff.a < cur_ff.b);
         end
         OP_MUL: begin
            r = (cur_ff.neg ? (~lo) + 64'd1 : lo) & mask;
            limit = min_of(cur_ff.wsel) - {63'd0, (!cur_ff.neg || lo == 64'd0)};
            if (cur_ff.sgn) begin
               ovf = (acc_ff[127:64] != 64'd0) || (lo > limit);
            end else begin
               ovf = (acc_ff[127:64] != 64'd0) || ((lo & ~mask) != 64'd0);
            end
         end
         OP_DIV: begin
            if (cur_ff.div_zero || cur_ff.div_min_m1) begin
               r = '0;
               ovf = 1'b1;
            end else begin
               r = (cur_ff.neg ? (~quo_ff) + 64'd1 : quo_ff) & mask;
            end
         end
         default: begin
            r = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               cur_in = head;
               acc_in = '0;
               rem_in = '0;
               cnt_in = '0;
               case (head.wsel)
                  2'd0:    quo_in = {head.ua[7:0], 56'd0};
                  2'd1:    quo_in = {head.ua[15:0], 48'd0};
                  2'd2:    quo_in = {head.ua[31:0], 32'd0};
                  default: quo_in = head.ua;
               endcase
               case (head.op)
                  OP_MUL: state_in = S_MUL;
                  OP_DIV: begin
                     state_in = S_DIV;
                     cnt_in = 6'((8 << head.wsel) - 1);
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_MUL: begin
            case (cnt_ff[1:0])
               2'd0:    acc_in = acc_ff + {64'd0, pp};
               2'd3:    acc_in = acc_ff + {pp, 64'd0};
               default: acc_in = acc_ff + {32'd0, pp, 32'd0};
            endcase
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            if (trial >= {1'b0, cur_ff.ub}) begin
               rem_in = trial - {1'b0, cur_ff.ub};
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            rsp_in.result   = r;
            rsp_in.overflow = ovf;
            strobe_in       = 1'b1;
            state_in        = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

endmodule

### hw/rtl/checked_integer_alu.sv
// Top level of the checked integer ALU: front end, item queue, back end.
// Depends on cia_pkg, cia_front, cia_queue and cia_back.
//
//   channel   ports                         handshake
//   request   start, busy, req_data         taken when start && !busy
//   response  rsp_strobe, rsp_data          one-cycle strobe, no stall
//
// Items enter at one per cycle until the four-entry queue fills; busy is
// queue full. The back end handles one item at a time: add or subtract
// directly, multiply in four partial products and divide at one quotient
// bit a cycle, so the back end sets the sustained rate. Results come out
// in order. Synchronous reset empties the queue and idles the back end.
module checked_integer_alu import cia_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   work_type front_work;
   work_type head;
   logic     full;
   logic     empty;
   logic     pop;

   assign busy = full;

   cia_front u_front (
      .req_data (req_data),
      .work     (front_work)
   );

   cia_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start && !full),
      .push_data (front_work),
      .pop       (pop),
      .pop_data  (head),
      .full      (full),
      .empty     (empty)
   );

   cia_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### verif/checked_integer_alu_test.sv
// Testbench for checked_integer_alu: drives random and corner-case operations
// and checks each result and overflow flag against an in-bench predictor.
// Depends on cia_pkg and the checked_integer_alu RTL.
`timescale 1ns / 100ps

module checked_integer_alu_test;
   import cia_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type pending_ops[$];
   rsp_type expected_results[$];
   int      error_count;
   int      idle_left;
   logic    in_taken;

   checked_integer_alu dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] abs_val(logic [63:0] x, int w);
      logic [63:0] m;
      m = (w == 64) ? '1 : ((64'd1 << w) - 1);
      if (x[w-1]) return (~x + 64'd1) & m;
      return x;
   endfunction

   function automatic rsp_type predict_alu(req_type q);
      rsp_type     p;
      int          w;
      logic [63:0] m, a, b, r, minv, qt;
      logic [127:0] prod, lim;
      logic        ovf, neg;
      w = 8 << q.width_sel;
      m = (w == 64) ? '1 : ((64'd1 << w) - 1);
      minv = 64'd1 << (w - 1);
      a = q.operand_a & m;
      b = q.operand_b & m;
      r = '0;
      ovf = 1'b0;
      case (op_type'(q.mode))
         OP_ADD: begin
            r = (a + b) & m;
            ovf = q.is_signed ? ((a ^ r) & (b ^ r) & minv) != 0 : r < a;
         end
         OP_SUB: begin
            r = (a - b) & m;
            ovf = q.is_signed ? ((a ^ b) & (a ^ r) & minv) != 0 : a < b;
         end
         OP_MUL: begin
            r = (a * b) & m;
            if (q.is_signed) begin
               neg = a[w-1] ^ b[w-1];
               prod = {64'd0, abs_val(a, w)} * {64'd0, abs_val(b, w)};
               lim = {64'd0, minv};
               if (!neg || prod == 0) lim = lim - 128'd1;
               ovf = prod > lim;
            end else begin
               prod = {64'd0, a} * {64'd0, b};
               ovf = prod > {64'd0, m};
            end
         end
         default: begin
            if (b == 0) begin
               ovf = 1'b1;
            end else if (q.is_signed) begin
               if (a == minv && b == m) begin
                  ovf = 1'b1;
               end else begin
                  qt = abs_val(a, w) / abs_val(b, w);
                  if (a[w-1] ^ b[w-1]) qt = ~qt + 64'd1;
                  r = qt & m;
               end
            end else begin
               r = a / b;
            end
         end
      endcase
      p.result = r & m;
      p.overflow = ovf;
      return p;
   endfunction

   function automatic logic [63:0] pick_operand(logic [1:0] wsel);
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = 64'd1;
         2: v = '1;
         3: v = min_of(wsel);
         4: v = min_of(wsel) - 64'd1;
         5: v = 64'($urandom_range(0, 15));
         6: v = mask_of(wsel) - 64'($urandom_range(0, 15));
         default: v = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 1) != 0) v = v | (~mask_of(wsel) & {$urandom, $urandom});
      return v;
   endfunction

   task automatic add_op(op_type op, logic sgn, logic [1:0] wsel,
                         logic [63:0] a, logic [63:0] b);
      req_type q;
      q.mode = op;
      q.is_signed = sgn;
      q.width_sel = wsel;
      q.operand_a = a;
      q.operand_b = b;
      pending_ops.push_back(q);
   endtask

   function automatic int pick_gap();
      int g;
      g = $urandom_range(0, 9);
      if (g < 6) return 0;
      if (g < 9) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else if (start && !in_taken) begin
      end else if (idle_left > 0) begin
         start <= 1'b0;
         idle_left <= idle_left - 1;
      end else if (pending_ops.size() > 0) begin
         req_data <= pending_ops.pop_front();
         start <= 1'b1;
         if ($urandom_range(0, 3) == 0) idle_left <= pick_gap();
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      in_taken <= !reset && start && !busy;
      if (!reset && start && !busy)
         expected_results.push_back(predict_alu(req_data));
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h/%b", $time,
                     rsp_data.result, rsp_data.overflow);
            error_count++;
         end else begin
            rsp_type e;
            e = expected_results.pop_front();
            if (e.result !== rsp_data.result || e.overflow !== rsp_data.overflow) begin
               $display("%0t: expected %h/%b actual %h/%b", $time, e.result,
                        e.overflow, rsp_data.result, rsp_data.overflow);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [1:0] wsel;
      reset = 1'b1;
      start = 1'b0;
      in_taken = 1'b0;
      req_data = '0;
      error_count = 0;
      idle_left = 0;
      for (int w = 0; w < 4; w++) begin
         add_op(OP_DIV, 1'b1, 2'(w), min_of(2'(w)), '1);
         add_op(OP_DIV, 1'b1, 2'(w), '1, min_of(2'(w)));
         add_op(OP_DIV, w[0], 2'(w), 64'd5, '0);
         add_op(OP_MUL, 1'b1, 2'(w), min_of(2'(w)), '1);
         add_op(OP_ADD, 1'b0, 2'(w), '1, 64'd1);
         add_op(OP_SUB, 1'b1, 2'(w), min_of(2'(w)), 64'd1);
      end
      add_op(OP_MUL, 1'b0, 2'd3, '1, '1);
      repeat (4) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      repeat (1050) begin
         wsel = 2'($urandom_range(0, 3));
         add_op(op_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), wsel,
                pick_operand(wsel), pick_operand(wsel));
      end
      wait (pending_ops.size() == 0 && !start);
      wait (expected_results.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
